// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that ante implies cons in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Checks that ante implies cons in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/sha256d_pkg.sv -----
// ---------------------------------------------------------------------------
// sha256d_pkg: shared types and constants
// Round constants, initial hash value and controller types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sha256d_pkg;

  localparam int unsigned HdrWords = 20;
  localparam logic [31:0] FirstLenBits = 32'd640;
  localparam logic [31:0] SecondLenBits = 32'd256;
  localparam logic [31:0] PadWord = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       load_block;
    logic [1:0] phase;
    logic       init_chain;
    logic       do_round;
    logic [5:0] round;
    logic       add_chain;
    logic       save_first;
  } dp_cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[i];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

endpackage
`default_nettype wire

// ----- design/sha256d_ctrl.sv -----
// ---------------------------------------------------------------------------
// sha256d_ctrl: sequencing controller
// Counts header words and steps the datapath through three compressions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha256d_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  output logic                      store_en,
  output logic [4:0]                store_idx,
  output sha256d_pkg::dp_cmd_t      cmd,
  output logic                      out_valid,
  output logic [2:0]                out_idx
);

  sha256d_pkg::state_t state, state_next;
  logic [4:0] words_received, words_received_next;
  logic [5:0] round_index, round_index_next;
  logic [1:0] block_phase, block_phase_next;
  logic [2:0] out_count, out_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256d_pkg::ST_IDLE;
      words_received <= '0;
      round_index <= '0;
      block_phase <= '0;
      out_count <= '0;
    end else begin
      state <= state_next;
      words_received <= words_received_next;
      round_index <= round_index_next;
      block_phase <= block_phase_next;
      out_count <= out_count_next;
    end
  end

  always_comb begin
    state_next = state;
    words_received_next = words_received;
    round_index_next = round_index;
    block_phase_next = block_phase;
    out_count_next = out_count;
    busy = 1'b1;
    store_en = 1'b0;
    store_idx = words_received;
    cmd = '0;
    cmd.phase = block_phase;
    cmd.round = round_index;
    out_valid = 1'b0;
    out_idx = out_count;
    unique case (state)
      sha256d_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          store_en = 1'b1;
          if (words_received == 5'(sha256d_pkg::HdrWords - 1)) begin
            words_received_next = '0;
            block_phase_next = '0;
            state_next = sha256d_pkg::ST_LOAD;
          end else begin
            words_received_next = words_received + 5'd1;
          end
        end
      end
      sha256d_pkg::ST_LOAD: begin
        cmd.load_block = 1'b1;
        cmd.init_chain = (block_phase != 2'd1);
        round_index_next = '0;
        state_next = sha256d_pkg::ST_ROUND;
      end
      sha256d_pkg::ST_ROUND: begin
        cmd.do_round = 1'b1;
        round_index_next = round_index + 6'd1;
        if (round_index == 6'd63) begin
          state_next = sha256d_pkg::ST_ADD;
        end
      end
      sha256d_pkg::ST_ADD: begin
        cmd.add_chain = 1'b1;
        cmd.save_first = (block_phase == 2'd1);
        if (block_phase == 2'd2) begin
          block_phase_next = '0;
          out_count_next = '0;
          state_next = sha256d_pkg::ST_OUT;
        end else begin
          block_phase_next = block_phase + 2'd1;
          state_next = sha256d_pkg::ST_LOAD;
        end
      end
      sha256d_pkg::ST_OUT: begin
        out_valid = 1'b1;
        out_count_next = out_count + 3'd1;
        if (out_count == 3'd7) begin
          state_next = sha256d_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256d_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/sha256d_dp.sv -----
// ---------------------------------------------------------------------------
// sha256d_dp: hash datapath
// Header store, message schedule window, working variables and chain value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha256d_dp (
  input  wire logic                 clk,
  input  wire logic                 store_en,
  input  wire logic [4:0]           store_idx,
  input  wire logic [31:0]          header_word,
  input  wire sha256d_pkg::dp_cmd_t cmd,
  input  wire logic [2:0]           out_idx,
  output logic [31:0]               digest_word
);

  logic [31:0] header_store [20];
  logic [31:0] schedule_window [16];
  logic [31:0] working_vars [8];
  logic [31:0] chain_value [8];
  logic [31:0] first_digest [8];
  logic [31:0] blk [16];
  logic [31:0] w15, w2, sg0, sg1, w_new, w_cur;
  logic [31:0] s1, ch, t1, s0, maj, t2;
  logic [31:0] chain_src [8];
  logic [31:0] sel;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      blk[i] = '0;
    end
    unique case (cmd.phase)
      2'd0: begin
        for (int i = 0; i < 16; i++) begin
          blk[i] = header_store[i];
        end
      end
      2'd1: begin
        for (int i = 0; i < 4; i++) begin
          blk[i] = header_store[16 + i];
        end
        blk[4] = sha256d_pkg::PadWord;
        blk[15] = sha256d_pkg::FirstLenBits;
      end
      default: begin
        for (int i = 0; i < 8; i++) begin
          blk[i] = first_digest[i];
        end
        blk[8] = sha256d_pkg::PadWord;
        blk[15] = sha256d_pkg::SecondLenBits;
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      chain_src[i] = cmd.init_chain ? sha256d_pkg::init_h(3'(i)) : chain_value[i];
    end
  end

  // The window shifts every round, so the oldest word is always at index 0.
  always_comb begin
    w15 = schedule_window[1];
    w2 = schedule_window[14];
    sg0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    sg1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    w_new = schedule_window[0] + sg0 + schedule_window[9] + sg1;
    w_cur = (cmd.round < 6'd16) ? schedule_window[0] : w_new;
    s1 = {working_vars[4][5:0], working_vars[4][31:6]}
       ^ {working_vars[4][10:0], working_vars[4][31:11]}
       ^ {working_vars[4][24:0], working_vars[4][31:25]};
    ch = (working_vars[4] & working_vars[5]) ^ (~working_vars[4] & working_vars[6]);
    t1 = working_vars[7] + s1 + ch + sha256d_pkg::round_k(cmd.round) + w_cur;
    s0 = {working_vars[0][1:0], working_vars[0][31:2]}
       ^ {working_vars[0][12:0], working_vars[0][31:13]}
       ^ {working_vars[0][21:0], working_vars[0][31:22]};
    maj = (working_vars[0] & working_vars[1]) ^ (working_vars[0] & working_vars[2])
        ^ (working_vars[1] & working_vars[2]);
    t2 = s0 + maj;
  end

  always_ff @(posedge clk) begin
    if (store_en) begin
      header_store[store_idx] <= header_word;
    end
    if (cmd.load_block) begin
      for (int i = 0; i < 16; i++) begin
        schedule_window[i] <= blk[i];
      end
      for (int i = 0; i < 8; i++) begin
        chain_value[i] <= chain_src[i];
        working_vars[i] <= chain_src[i];
      end
    end
    if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) begin
        schedule_window[i] <= schedule_window[i + 1];
      end
      schedule_window[15] <= w_cur;
      for (int i = 1; i < 8; i++) begin
        working_vars[i] <= working_vars[i - 1];
      end
      working_vars[4] <= working_vars[3] + t1;
      working_vars[0] <= t1 + t2;
    end
    if (cmd.add_chain) begin
      for (int i = 0; i < 8; i++) begin
        chain_value[i] <= chain_value[i] + working_vars[i];
      end
    end
    if (cmd.save_first) begin
      for (int i = 0; i < 8; i++) begin
        first_digest[i] <= chain_value[i] + working_vars[i];
      end
    end
  end

  always_comb begin
    sel = chain_value[3'd7 - out_idx];
    digest_word = {sel[7:0], sel[15:8], sel[23:16], sel[31:24]};
  end

endmodule
`default_nettype wire

// ----- design/double_sha256_header_hash.sv -----
// ---------------------------------------------------------------------------
// double_sha256_header_hash: double SHA-256 of an 80-byte block header
// Collects 20 header words, hashes twice and returns 8 byte-reversed words.
// ---------------------------------------------------------------------------
// Header words 1 to 19 are each stored with no result. After the twentieth
// word, three compressions run at one round per cycle, then the 8 digest
// words follow back to back. Busy stays high until the last result.
// Synchronous reset returns the block to idle with the word count at zero.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module double_sha256_header_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] header_word,
  output logic             strobe,
  output logic [31:0]      digest_word,
  output logic             last_word
);

  sha256d_pkg::dp_cmd_t cmd;
  logic       store_en;
  logic [4:0] store_idx;
  logic [2:0] out_idx;

  sha256d_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .store_en(store_en), .store_idx(store_idx), .cmd(cmd),
    .out_valid(strobe), .out_idx(out_idx)
  );

  sha256d_dp u_dp (
    .clk(clk), .store_en(store_en), .store_idx(store_idx),
    .header_word(header_word), .cmd(cmd), .out_idx(out_idx),
    .digest_word(digest_word)
  );

  assign last_word = strobe && (out_idx == 3'd7);

  `ASSERT_SAME(a_no_store_busy, clk, rst, busy, !store_en, "header stored while busy")
  `ASSERT_SAME(a_strobe_busy, clk, rst, strobe, busy, "result while idle")
  `ASSERT_NEXT(a_last_ends, clk, rst, last_word, !strobe && !busy, "run did not end")

endmodule
`default_nettype wire
